@@ hw/rtl/sls_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sls_pkg
// Types and codes shared by the sequential list store modules.
// ----------------------------------------------------------------------------
package sls_pkg;

    localparam int OP_W    = 3;
    localparam int IDX_W   = 8;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;
    localparam int POS_W   = 7;
    localparam int CNT_W   = 8;

    localparam logic [OP_W-1:0] OP_GET    = 3'd0;
    localparam logic [OP_W-1:0] OP_LOCATE = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]         operation;
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] value;
    } sls_in_t;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic signed [VAL_W-1:0] value_out;
        logic [POS_W-1:0]        position;
        logic [CNT_W-1:0]        count;
        logic                    empty_res;
    } sls_out_t;

    typedef enum logic [2:0] {
        ACT_IDLE,
        ACT_LOAD_IDX,
        ACT_LOAD_VAL,
        ACT_SHIFT,
        ACT_INSERT,
        ACT_DELETE
    } sls_act_t;

    typedef struct packed {
        sls_act_t                act;
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] value;
    } sls_cmd_t;

    typedef struct packed {
        logic             found;
        logic [VAL_W-1:0] value;
    } sls_slot_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } sls_state_t;

endpackage

@@ hw/rtl/sls_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sls_cell
// One list position: the stored entry and a scan slot that hands its
// contents toward position zero while a query runs.
// ----------------------------------------------------------------------------
module sls_cell #(
    parameter int CAPACITY = 128,
    parameter int POS      = 0
) (
    input  logic                             aclk,
    input  sls_pkg::sls_cmd_t                cmd,
    input  logic [$clog2(CAPACITY+1)-1:0]    len,
    input  logic [sls_pkg::VAL_W-1:0]        entry_left,
    input  logic [sls_pkg::VAL_W-1:0]        entry_right,
    input  sls_pkg::sls_slot_t               slot_right,
    output logic [sls_pkg::VAL_W-1:0]        entry_o,
    output sls_pkg::sls_slot_t               slot_o
);
    import sls_pkg::*;

    logic [VAL_W-1:0] entry_reg;
    sls_slot_t        slot_reg;

    always_ff @(posedge aclk) begin
        case (cmd.act)
            ACT_LOAD_IDX: begin
                slot_reg.found <= (int'(cmd.index) == POS);
                slot_reg.value <= entry_reg;
            end
            ACT_LOAD_VAL: begin
                slot_reg.found <= (entry_reg == cmd.value) && (POS < int'(len));
                slot_reg.value <= entry_reg;
            end
            ACT_SHIFT: begin
                slot_reg <= slot_right;
            end
            ACT_INSERT: begin
                if (POS > int'(cmd.index)) begin
                    entry_reg <= entry_left;
                end else if (POS == int'(cmd.index)) begin
                    entry_reg <= cmd.value;
                end
            end
            ACT_DELETE: begin
                if (POS >= int'(cmd.index)) begin
                    entry_reg <= entry_right;
                end
            end
            default: begin
            end
        endcase
    end

    assign entry_o = entry_reg;
    assign slot_o  = slot_reg;

endmodule

@@ hw/rtl/sls_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sls_ctrl
// Sequencer: decodes each beat, holds the list length, runs the scan of the
// cell chain and registers the result beat.
// ----------------------------------------------------------------------------
module sls_ctrl #(
    parameter int CAPACITY = 128
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  sls_pkg::sls_in_t                  s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output sls_pkg::sls_out_t                 m_data,
    input  sls_pkg::sls_slot_t                slot_head,
    output sls_pkg::sls_cmd_t                 cmd,
    output logic [$clog2(CAPACITY+1)-1:0]     len
);
    import sls_pkg::*;

    localparam int LW = $clog2(CAPACITY + 1);
    localparam int PW = $clog2(CAPACITY);
    localparam int CW = (LW > IDX_W) ? LW : IDX_W;

    sls_state_t         state_reg, state_next;
    logic [LW-1:0]      len_reg, len_next;
    logic [PW-1:0]      cnt_reg, cnt_next;
    logic [OP_W-1:0]    op_reg, op_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               m_valid_reg, m_valid_next;
    sls_out_t           m_data_reg, m_data_next;

    logic               out_free;
    logic               accept;
    logic               res_load;
    logic [STAT_W-1:0]  res_status;
    logic [VAL_W-1:0]   res_value;
    logic [PW-1:0]      res_pos;
    logic [CW-1:0]      idx_ext;
    logic [CW-1:0]      len_ext;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign idx_ext  = CW'(s_data.index);
    assign len_ext  = CW'(len_reg);

    always_comb begin
        state_next   = state_reg;
        len_next     = len_reg;
        cnt_next     = cnt_reg;
        op_next      = op_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        res_load     = 1'b0;
        res_status   = ST_OK;
        res_value    = '0;
        res_pos      = '0;
        cmd.act      = ACT_IDLE;
        cmd.index    = s_data.index;
        cmd.value    = s_data.value;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_next  = s_data.operation;
                    idx_next = s_data.index;
                    cnt_next = '0;
                    case (s_data.operation)
                        OP_GET, OP_DELETE: begin
                            if (idx_ext < len_ext) begin
                                cmd.act    = ACT_LOAD_IDX;
                                state_next = ST_SCAN;
                            end else begin
                                res_load   = 1'b1;
                                res_status = ST_BAD_INDEX;
                            end
                        end
                        OP_LOCATE: begin
                            if (len_reg != '0) begin
                                cmd.act    = ACT_LOAD_VAL;
                                state_next = ST_SCAN;
                            end else begin
                                res_load   = 1'b1;
                                res_status = ST_NOT_FOUND;
                            end
                        end
                        OP_INSERT: begin
                            res_load = 1'b1;
                            if (idx_ext > len_ext) begin
                                res_status = ST_BAD_INDEX;
                            end else if (len_reg == LW'(CAPACITY)) begin
                                res_status = ST_FULL;
                            end else begin
                                cmd.act  = ACT_INSERT;
                                len_next = len_reg + 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            res_load = 1'b1;
                            len_next = '0;
                        end
                        default: begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                cmd.index = idx_reg;
                if (slot_head.found || (LW'(cnt_reg) + 1'b1 >= len_reg)) begin
                    if (out_free) begin
                        res_load   = 1'b1;
                        state_next = ST_IDLE;
                        if (slot_head.found) begin
                            if (op_reg == OP_LOCATE) begin
                                res_pos = cnt_reg;
                            end else begin
                                res_value = slot_head.value;
                            end
                            if (op_reg == OP_DELETE) begin
                                cmd.act  = ACT_DELETE;
                                len_next = len_reg - 1'b1;
                            end
                        end else begin
                            res_status = ST_NOT_FOUND;
                        end
                    end
                end else begin
                    cmd.act  = ACT_SHIFT;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (res_load) begin
            m_valid_next          = 1'b1;
            m_data_next.status    = res_status;
            m_data_next.value_out = res_value;
            m_data_next.position  = POS_W'(res_pos);
            m_data_next.count     = CNT_W'(len_next);
            m_data_next.empty_res = (len_next == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            len_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        idx_reg    <= idx_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign len     = len_reg;

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LW'(CAPACITY))
        else $error("list length above capacity");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (LW'(cnt_reg) < len_reg))
        else $error("scan position beyond list length");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.operation == OP_CLEAR) |=> (len_reg == '0))
        else $error("clear did not empty the list");

    a_scan_holds_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> !s_ready)
        else $error("beat accepted during scan");

endmodule

@@ hw/rtl/sequential_list_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequential_list_store
// Ordered list of signed 32-bit values in a chain of CAPACITY cells.
//
// s_* carries one operation beat (get, locate, insert, delete, clear) and
// m_* returns exactly one result beat per operation, in order.
// Insert, clear, unused codes and refused operations: the result is
// registered straight from the taken beat. Get, delete and locate scan:
// the query slots shift one cell per cycle toward position zero, where the
// sequencer inspects them, so the scan runs on to index i for get and delete,
// and to the found position, or to the end of the list, for locate.
// One operation is in progress at a time; the next beat is taken once the
// sequencer is idle and the result register is free or being drained.
// Reset empties the list; the cell contents are not cleared.
// When m_ready is low the result beat holds and a scan that has its answer
// waits; no beat is lost.
// ----------------------------------------------------------------------------
module sequential_list_store #(
    parameter int CAPACITY = 128
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sls_pkg::sls_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output sls_pkg::sls_out_t  m_data
);
    import sls_pkg::*;

    localparam int LW = $clog2(CAPACITY + 1);

    sls_cmd_t          cmd;
    logic [LW-1:0]     len;
    logic [VAL_W-1:0]  entry_w [CAPACITY];
    sls_slot_t         slot_w  [CAPACITY];
    sls_slot_t         slot_end;

    assign slot_end = '{found: 1'b0, value: '0};

    sls_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .slot_head (slot_w[0]),
        .cmd       (cmd),
        .len       (len)
    );

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        sls_cell #(
            .CAPACITY (CAPACITY),
            .POS      (k)
        ) u_cell (
            .aclk        (aclk),
            .cmd         (cmd),
            .len         (len),
            .entry_left  (entry_w[(k == 0) ? 0 : k - 1]),
            .entry_right (entry_w[(k == CAPACITY - 1) ? k : k + 1]),
            .slot_right  ((k == CAPACITY - 1) ? slot_end
                                              : slot_w[(k == CAPACITY - 1) ? k : k + 1]),
            .entry_o     (entry_w[k]),
            .slot_o      (slot_w[k])
        );
    end

endmodule
